// ===== hdl/mlfs_pkg.sv =====
package mlfs_pkg;

    // sizing
    localparam int LEVELS    = 3;
    localparam int JOB_SLOTS = 16;

    // field widths
    localparam int ID_W      = 8;
    localparam int TIME_W    = 16;
    localparam int KIND_W    = 2;
    localparam int LVL_OUT_W = 2;

    // derived widths
    localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W   = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam int CNT_W   = $clog2(JOB_SLOTS + 1);
    localparam int DEPTH   = LEVELS * JOB_SLOTS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ENTRY_W = ID_W + TIME_W + 1;

    // command codes
    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // stop codes
    localparam logic [KIND_W-1:0] STOP_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] STOP_FINISH  = 2'd1;
    localparam logic [KIND_W-1:0] STOP_PREEMPT = 2'd2;

    // start codes
    localparam logic [KIND_W-1:0] START_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] START_FIRST  = 2'd1;
    localparam logic [KIND_W-1:0] START_RESUME = 2'd2;

    // queue entry layout
    typedef struct packed {
        logic              started;
        logic [TIME_W-1:0] remaining;
        logic [ID_W-1:0]   id;
    } mlfs_entry_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic do_submit;
        logic do_stop;
        logic do_pick;
        logic do_load;
        logic do_finish;
    } mlfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic dispatch;
    } mlfs_stat_t;

endpackage

// ===== hdl/mlfs_ctrl.sv =====
module mlfs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output mlfs_pkg::mlfs_cmd_t cmd,
    input  mlfs_pkg::mlfs_stat_t stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SUBMIT = 3'd1;
    localparam logic [2:0] S_STOP   = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_LOAD   = 3'd4;
    localparam logic [2:0] S_FINAL  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SUBMIT;
                end
            end
            S_SUBMIT:
            begin
                // latched command decides the path
                if (stat.is_tick)
                begin
                    state_next = S_STOP;
                end
                else
                begin
                    cmd.do_submit = 1'b1;
                    state_next    = S_FINAL;
                end
            end
            S_STOP:
            begin
                cmd.do_stop = 1'b1;
                state_next  = S_PICK;
            end
            S_PICK:
            begin
                cmd.do_pick = 1'b1;
                state_next  = stat.dispatch ? S_LOAD : S_FINAL;
            end
            S_LOAD:
            begin
                cmd.do_load = 1'b1;
                state_next  = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.do_finish = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hdl/mlfs_datapath.sv =====
module mlfs_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mlfs_pkg::mlfs_cmd_t                   cmd,
    output mlfs_pkg::mlfs_stat_t                  stat,
    input  logic                                  command,
    input  logic [mlfs_pkg::ID_W-1:0]             job_id,
    input  logic [mlfs_pkg::TIME_W-1:0]           cpu_time,
    output logic                                  done,
    output logic                                  accepted,
    output logic [mlfs_pkg::KIND_W-1:0]           stop_kind,
    output logic [mlfs_pkg::ID_W-1:0]             stopped_job,
    output logic [mlfs_pkg::KIND_W-1:0]           start_kind,
    output logic                                  running_valid,
    output logic [mlfs_pkg::ID_W-1:0]             running_job,
    output logic [mlfs_pkg::LVL_OUT_W-1:0]        running_level,
    output logic [mlfs_pkg::TIME_W-1:0]           running_remaining,
    output logic                                  all_idle
);

    // queue store
    mlfs_pkg::mlfs_entry_t mem [mlfs_pkg::DEPTH];
    mlfs_pkg::mlfs_entry_t rd_data_reg;
    logic                          wr_en;
    logic [mlfs_pkg::ADDR_W-1:0]   wr_addr;
    mlfs_pkg::mlfs_entry_t         wr_data;
    logic                          rd_en;
    logic [mlfs_pkg::ADDR_W-1:0]   rd_addr;

    // per-level pointers and counts
    logic [mlfs_pkg::PTR_W-1:0] head_reg  [mlfs_pkg::LEVELS];
    logic [mlfs_pkg::PTR_W-1:0] head_next [mlfs_pkg::LEVELS];
    logic [mlfs_pkg::PTR_W-1:0] tail_reg  [mlfs_pkg::LEVELS];
    logic [mlfs_pkg::PTR_W-1:0] tail_next [mlfs_pkg::LEVELS];
    logic [mlfs_pkg::CNT_W-1:0] count_reg [mlfs_pkg::LEVELS];
    logic [mlfs_pkg::CNT_W-1:0] count_next[mlfs_pkg::LEVELS];
    logic [mlfs_pkg::CNT_W-1:0] held_reg;
    logic [mlfs_pkg::CNT_W-1:0] held_next;

    // running job
    logic                        run_valid_reg;
    logic                        run_valid_next;
    logic [mlfs_pkg::ID_W-1:0]   run_job_reg;
    logic [mlfs_pkg::ID_W-1:0]   run_job_next;
    logic [mlfs_pkg::LVL_W-1:0]  run_level_reg;
    logic [mlfs_pkg::LVL_W-1:0]  run_level_next;
    logic [mlfs_pkg::TIME_W-1:0] run_rem_reg;
    logic [mlfs_pkg::TIME_W-1:0] run_rem_next;

    // latched beat
    logic                        cmd_tick_reg;
    logic [mlfs_pkg::ID_W-1:0]   id_reg;
    logic [mlfs_pkg::TIME_W-1:0] time_reg;

    // per-step result scratch
    logic                        acc_reg;
    logic                        acc_next;
    logic [mlfs_pkg::KIND_W-1:0] stop_reg;
    logic [mlfs_pkg::KIND_W-1:0] stop_next;
    logic [mlfs_pkg::ID_W-1:0]   stopped_reg;
    logic [mlfs_pkg::ID_W-1:0]   stopped_next;
    logic [mlfs_pkg::KIND_W-1:0] startk_reg;
    logic [mlfs_pkg::KIND_W-1:0] startk_next;
    logic [mlfs_pkg::LVL_W-1:0]  pick_reg;
    logic [mlfs_pkg::LVL_W-1:0]  pick_next;

    // result registers
    logic                           done_reg;
    logic                           done_next;
    logic                           out_acc_reg;
    logic [mlfs_pkg::KIND_W-1:0]    out_stop_reg;
    logic [mlfs_pkg::ID_W-1:0]      out_stopped_reg;
    logic [mlfs_pkg::KIND_W-1:0]    out_startk_reg;
    logic                           out_rv_reg;
    logic [mlfs_pkg::ID_W-1:0]      out_job_reg;
    logic [mlfs_pkg::LVL_OUT_W-1:0] out_lvl_reg;
    logic [mlfs_pkg::TIME_W-1:0]    out_rem_reg;
    logic                           out_idle_reg;

    // priority pick
    logic                       any_queued;
    logic [mlfs_pkg::LVL_W-1:0] first_lvl;
    logic [mlfs_pkg::LVL_W-1:0] demote_lvl;

    function automatic logic [mlfs_pkg::PTR_W-1:0] ptr_inc(
        input logic [mlfs_pkg::PTR_W-1:0] p
    );
        if (p == mlfs_pkg::PTR_W'(mlfs_pkg::JOB_SLOTS - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [mlfs_pkg::ADDR_W-1:0] addr_of(
        input logic [mlfs_pkg::LVL_W-1:0] lvl,
        input logic [mlfs_pkg::PTR_W-1:0] p
    );
        return mlfs_pkg::ADDR_W'(mlfs_pkg::ADDR_W'(lvl) *
                                 mlfs_pkg::ADDR_W'(mlfs_pkg::JOB_SLOTS) +
                                 mlfs_pkg::ADDR_W'(p));
    endfunction

    // highest non-empty level, level 0 first
    always_comb
    begin
        any_queued = 1'b0;
        first_lvl  = '0;
        for (int i = mlfs_pkg::LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                any_queued = 1'b1;
                first_lvl  = mlfs_pkg::LVL_W'(i);
            end
        end
    end

    // demotion saturates at the lowest level
    assign demote_lvl = (run_level_reg == mlfs_pkg::LVL_W'(mlfs_pkg::LEVELS - 1)) ?
                        run_level_reg : run_level_reg + 1'b1;

    assign stat.is_tick  = cmd_tick_reg;
    assign stat.dispatch = !run_valid_reg && any_queued;

    // step datapath
    always_comb
    begin
        for (int i = 0; i < mlfs_pkg::LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
        end
        held_next      = held_reg;
        run_valid_next = run_valid_reg;
        run_job_next   = run_job_reg;
        run_level_next = run_level_reg;
        run_rem_next   = run_rem_reg;
        acc_next       = acc_reg;
        stop_next      = stop_reg;
        stopped_next   = stopped_reg;
        startk_next    = startk_reg;
        pick_next      = pick_reg;
        done_next      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        // new beat clears the scratch
        if (cmd.capture)
        begin
            acc_next     = 1'b1;
            stop_next    = mlfs_pkg::STOP_NONE;
            stopped_next = '0;
            startk_next  = mlfs_pkg::START_NONE;
        end

        // enqueue at level 0 unless slots are full
        if (cmd.do_submit)
        begin
            if (held_reg == mlfs_pkg::CNT_W'(mlfs_pkg::JOB_SLOTS))
            begin
                acc_next = 1'b0;
            end
            else
            begin
                wr_en             = 1'b1;
                wr_addr           = addr_of('0, tail_reg[0]);
                wr_data.started   = 1'b0;
                wr_data.remaining = time_reg;
                wr_data.id        = id_reg;
                tail_next[0]      = ptr_inc(tail_reg[0]);
                count_next[0]     = count_reg[0] + 1'b1;
                held_next         = held_reg + 1'b1;
            end
        end

        // serve the running job: finish or preempt
        if (cmd.do_stop && run_valid_reg)
        begin
            if (run_rem_reg <= mlfs_pkg::TIME_W'(1))
            begin
                stop_next      = mlfs_pkg::STOP_FINISH;
                stopped_next   = run_job_reg;
                run_valid_next = 1'b0;
                if (held_reg != '0)
                begin
                    held_next = held_reg - 1'b1;
                end
            end
            else
            begin
                run_rem_next = run_rem_reg - 1'b1;
                if (any_queued)
                begin
                    stop_next              = mlfs_pkg::STOP_PREEMPT;
                    stopped_next           = run_job_reg;
                    run_valid_next         = 1'b0;
                    wr_en                  = 1'b1;
                    wr_addr                = addr_of(demote_lvl, tail_reg[demote_lvl]);
                    wr_data.started        = 1'b1;
                    wr_data.remaining      = run_rem_reg - 1'b1;
                    wr_data.id             = run_job_reg;
                    tail_next[demote_lvl]  = ptr_inc(tail_reg[demote_lvl]);
                    count_next[demote_lvl] = count_reg[demote_lvl] + 1'b1;
                end
            end
        end

        // pop the head of the chosen level
        if (cmd.do_pick && stat.dispatch)
        begin
            rd_en                 = 1'b1;
            rd_addr               = addr_of(first_lvl, head_reg[first_lvl]);
            head_next[first_lvl]  = ptr_inc(head_reg[first_lvl]);
            count_next[first_lvl] = count_reg[first_lvl] - 1'b1;
            pick_next             = first_lvl;
        end

        // load the dispatched job
        if (cmd.do_load)
        begin
            run_valid_next = 1'b1;
            run_job_next   = rd_data_reg.id;
            run_rem_next   = rd_data_reg.remaining;
            run_level_next = pick_reg;
            startk_next    = rd_data_reg.started ? mlfs_pkg::START_RESUME :
                                                   mlfs_pkg::START_FIRST;
        end

        if (cmd.do_finish)
        begin
            done_next = 1'b1;
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // input beat latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            id_reg   <= job_id;
            time_reg <= cpu_time;
        end
    end

    // control and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mlfs_pkg::LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            held_reg      <= '0;
            run_valid_reg <= 1'b0;
            run_job_reg   <= '0;
            run_level_reg <= '0;
            run_rem_reg   <= '0;
            cmd_tick_reg  <= mlfs_pkg::CMD_SUBMIT;
            acc_reg       <= 1'b0;
            stop_reg      <= mlfs_pkg::STOP_NONE;
            stopped_reg   <= '0;
            startk_reg    <= mlfs_pkg::START_NONE;
            pick_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < mlfs_pkg::LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
            held_reg      <= held_next;
            run_valid_reg <= run_valid_next;
            run_job_reg   <= run_job_next;
            run_level_reg <= run_level_next;
            run_rem_reg   <= run_rem_next;
            if (cmd.capture)
            begin
                cmd_tick_reg <= (command == mlfs_pkg::CMD_TICK);
            end
            acc_reg     <= acc_next;
            stop_reg    <= stop_next;
            stopped_reg <= stopped_next;
            startk_reg  <= startk_next;
            pick_reg    <= pick_next;
            done_reg    <= done_next;
        end
    end

    // result beat registers
    always_ff @(posedge clk)
    begin
        if (cmd.do_finish)
        begin
            out_acc_reg     <= acc_reg;
            out_stop_reg    <= stop_reg;
            out_stopped_reg <= stopped_reg;
            out_startk_reg  <= startk_reg;
            out_rv_reg      <= run_valid_reg;
            out_job_reg     <= run_valid_reg ? run_job_reg : '0;
            out_lvl_reg     <= run_valid_reg ? mlfs_pkg::LVL_OUT_W'(run_level_reg) : '0;
            out_rem_reg     <= run_valid_reg ? run_rem_reg : '0;
            out_idle_reg    <= !run_valid_reg && !any_queued;
        end
    end

    assign done              = done_reg;
    assign accepted          = out_acc_reg;
    assign stop_kind         = out_stop_reg;
    assign stopped_job       = out_stopped_reg;
    assign start_kind        = out_startk_reg;
    assign running_valid     = out_rv_reg;
    assign running_job       = out_job_reg;
    assign running_level     = out_lvl_reg;
    assign running_remaining = out_rem_reg;
    assign all_idle          = out_idle_reg;

endmodule

// ===== hdl/multilevel_feedback_scheduler_core.sv =====
// channel   signals                               direction  handshake
// command   start, busy, command, job_id, cpu_time  in       start high while busy low
// result    done, accepted .. all_idle              out      done strobe, one cycle
//
// a submit beat passes the controller steps capture, submit and finish; a tick passes
// capture, the decision step, stop, pick, load when a job is dispatched, and finish;
// the result strobe is registered from the finish step, and the pace is set by the
// controller steps and the registered read of the queue store
// reset is asynchronous active low and clears all queues, counts and the running job
// results cannot be stalled; the next beat may be accepted in the cycle of the strobe
module multilevel_feedback_scheduler_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           command,
    input  logic [mlfs_pkg::ID_W-1:0]      job_id,
    input  logic [mlfs_pkg::TIME_W-1:0]    cpu_time,
    output logic                           done,
    output logic                           accepted,
    output logic [mlfs_pkg::KIND_W-1:0]    stop_kind,
    output logic [mlfs_pkg::ID_W-1:0]      stopped_job,
    output logic [mlfs_pkg::KIND_W-1:0]    start_kind,
    output logic                           running_valid,
    output logic [mlfs_pkg::ID_W-1:0]      running_job,
    output logic [mlfs_pkg::LVL_OUT_W-1:0] running_level,
    output logic [mlfs_pkg::TIME_W-1:0]    running_remaining,
    output logic                           all_idle
);

    mlfs_pkg::mlfs_cmd_t  cmd;
    mlfs_pkg::mlfs_stat_t stat;

    // sequencer
    mlfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // queues, running job and result registers
    mlfs_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .command           (command),
        .job_id            (job_id),
        .cpu_time          (cpu_time),
        .done              (done),
        .accepted          (accepted),
        .stop_kind         (stop_kind),
        .stopped_job       (stopped_job),
        .start_kind        (start_kind),
        .running_valid     (running_valid),
        .running_job       (running_job),
        .running_level     (running_level),
        .running_remaining (running_remaining),
        .all_idle          (all_idle)
    );

    // an accepted beat keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // a result strobe follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    // controller issues at most one step at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.do_submit, cmd.do_stop,
                  cmd.do_pick, cmd.do_load, cmd.do_finish}))
        else $error("controller issued overlapping steps");

    // a refused submit neither stops nor starts a job
    a_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accepted) |-> (stop_kind == mlfs_pkg::STOP_NONE &&
                                 start_kind == mlfs_pkg::START_NONE))
        else $error("refused submit changed the running job");

    // a running job means the scheduler is not idle
    a_run_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && running_valid) |-> !all_idle)
        else $error("idle flagged while a job runs");

endmodule

// ===== tb/multilevel_feedback_scheduler_core_test.sv =====
module multilevel_feedback_scheduler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mlfs_pkg::*;

    // one result beat as it appears on the result ports
    typedef struct packed {
        logic                 accepted;
        logic [KIND_W-1:0]    stop_kind;
        logic [ID_W-1:0]      stopped_job;
        logic [KIND_W-1:0]    start_kind;
        logic                 running_valid;
        logic [ID_W-1:0]      running_job;
        logic [LVL_OUT_W-1:0] running_level;
        logic [TIME_W-1:0]    running_remaining;
        logic                 all_idle;
    } sched_result_t;

    // one stimulus beat, with an optional hand-typed result
    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] t;
        logic            typed;
        sched_result_t   res;
    } stim_row_t;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BEATS = 1020;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 command;
    logic [ID_W-1:0]      job_id;
    logic [TIME_W-1:0]    cpu_time;
    logic                 done;
    logic                 accepted;
    logic [KIND_W-1:0]    stop_kind;
    logic [ID_W-1:0]      stopped_job;
    logic [KIND_W-1:0]    start_kind;
    logic                 running_valid;
    logic [ID_W-1:0]      running_job;
    logic [LVL_OUT_W-1:0] running_level;
    logic [TIME_W-1:0]    running_remaining;
    logic                 all_idle;

    // scheduler shadow state
    mlfs_entry_t       level_q [LEVELS][$];
    int                held_jobs;
    logic              run_on;
    logic [ID_W-1:0]   run_id;
    logic [LVL_W-1:0]  run_lvl;
    logic [TIME_W-1:0] run_left;

    sched_result_t expected_results[$];
    stim_row_t     dir_rows[$];
    int            mismatch_count;
    int            quiet_cycles;

    multilevel_feedback_scheduler_core DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .command           (command),
        .job_id            (job_id),
        .cpu_time          (cpu_time),
        .done              (done),
        .accepted          (accepted),
        .stop_kind         (stop_kind),
        .stopped_job       (stopped_job),
        .start_kind        (start_kind),
        .running_valid     (running_valid),
        .running_job       (running_job),
        .running_level     (running_level),
        .running_remaining (running_remaining),
        .all_idle          (all_idle)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // highest-priority level holding a job, -1 when all are empty
    function automatic int top_level();
        int lvl;
        lvl = -1;
        for (int n = LEVELS - 1; n >= 0; n--)
            if (level_q[n].size() != 0)
                lvl = n;
        return lvl;
    endfunction

    // advance the shadow scheduler by one beat and return its result
    function automatic sched_result_t schedule_step(input logic cmd,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [TIME_W-1:0] t);
        sched_result_t r;
        mlfs_entry_t   e;
        int            lvl;
        int            nl;
        r = '0;
        r.accepted = 1'b1;
        if (cmd == CMD_SUBMIT)
        begin
            // refuse when every slot is held
            if (held_jobs >= JOB_SLOTS)
                r.accepted = 1'b0;
            else
            begin
                e.started   = 1'b0;
                e.remaining = t;
                e.id        = id;
                if (level_q[0].size() < JOB_SLOTS)
                    level_q[0].push_back(e);
                held_jobs++;
            end
        end
        else
        begin
            // serve the running job
            if (run_on)
            begin
                if (run_left <= 1)
                begin
                    r.stop_kind   = STOP_FINISH;
                    r.stopped_job = run_id;
                    run_on = 1'b0;
                    if (held_jobs > 0)
                        held_jobs--;
                end
                else
                begin
                    run_left = run_left - 1'b1;
                    if (top_level() >= 0)
                    begin
                        nl = int'(run_lvl) + 1;
                        if (nl >= LEVELS)
                            nl = LEVELS - 1;
                        r.stop_kind   = STOP_PREEMPT;
                        r.stopped_job = run_id;
                        e.started   = 1'b1;
                        e.remaining = run_left;
                        e.id        = run_id;
                        if (level_q[nl].size() < JOB_SLOTS)
                            level_q[nl].push_back(e);
                        run_on = 1'b0;
                    end
                end
            end
            // dispatch within the same tick
            if (!run_on)
            begin
                lvl = top_level();
                if (lvl >= 0)
                begin
                    e = level_q[lvl].pop_front();
                    run_on   = 1'b1;
                    run_id   = e.id;
                    run_left = e.remaining;
                    run_lvl  = lvl[LVL_W-1:0];
                    r.start_kind = e.started ? START_RESUME : START_FIRST;
                end
            end
        end
        r.running_valid = run_on;
        if (run_on)
        begin
            r.running_job       = run_id;
            r.running_level     = LVL_OUT_W'(run_lvl);
            r.running_remaining = run_left;
        end
        r.all_idle = !run_on && (top_level() < 0);
        return r;
    endfunction

    task automatic add_row(input logic cmd, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] t, input logic typed,
                           input sched_result_t res);
        stim_row_t row;
        row.cmd   = cmd;
        row.id    = id;
        row.t     = t;
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endtask

    // drive one beat after an idle gap and log its expected result
    task automatic send_beat(input int gap, input stim_row_t row);
        sched_result_t predicted;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        command  <= row.cmd;
        job_id   <= row.id;
        cpu_time <= row.t;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = schedule_step(row.cmd, row.id, row.t);
        expected_results.push_back(row.typed ? row.res : predicted);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        sched_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no expectation pending");
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("accepted", want.accepted, accepted);
                check_field("stop_kind", want.stop_kind, stop_kind);
                check_field("stopped_job", want.stopped_job, stopped_job);
                check_field("start_kind", want.start_kind, start_kind);
                check_field("running_valid", want.running_valid, running_valid);
                check_field("running_job", want.running_job, running_job);
                check_field("running_level", want.running_level, running_level);
                check_field("running_remaining", want.running_remaining,
                            running_remaining);
                check_field("all_idle", want.all_idle, all_idle);
            end
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        stim_row_t row;
        int        beats_left;
        int        burst_len;
        int        submit_pct;
        int        long_jobs_left;
        bit        no_gap;

        rst_n          = 1'b0;
        start          = 1'b0;
        command        = CMD_SUBMIT;
        job_id         = '0;
        cpu_time       = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        held_jobs      = 0;
        run_on         = 1'b0;
        run_id         = '0;
        run_lvl        = '0;
        run_left       = '0;

        // tick on an empty scheduler
        add_row(CMD_TICK, 8'hAA, 16'h5555, 1'b1,
                '{1'b1, STOP_NONE, 8'h00, START_NONE, 1'b0, 8'h00, 2'd0, 16'h0000, 1'b1});
        // widest submit, no dispatch until a tick
        add_row(CMD_SUBMIT, 8'hFF, 16'hFFFF, 1'b1,
                '{1'b1, STOP_NONE, 8'h00, START_NONE, 1'b0, 8'h00, 2'd0, 16'h0000, 1'b0});
        add_row(CMD_TICK, 8'h55, 16'hAAAA, 1'b1,
                '{1'b1, STOP_NONE, 8'h00, START_FIRST, 1'b1, 8'hFF, 2'd0, 16'hFFFF, 1'b0});
        // lone job keeps running
        add_row(CMD_TICK, 8'h00, 16'h0000, 1'b1,
                '{1'b1, STOP_NONE, 8'h00, START_NONE, 1'b1, 8'hFF, 2'd0, 16'hFFFE, 1'b0});
        add_row(CMD_SUBMIT, 8'h00, 16'h0000, 1'b1,
                '{1'b1, STOP_NONE, 8'h00, START_NONE, 1'b1, 8'hFF, 2'd0, 16'hFFFE, 1'b0});
        // preempt and dispatch in the same tick
        add_row(CMD_TICK, 8'hFF, 16'hFFFF, 1'b1,
                '{1'b1, STOP_PREEMPT, 8'hFF, START_FIRST, 1'b1, 8'h00, 2'd0, 16'h0000, 1'b0});
        // zero-time job finishes, demoted job resumes
        add_row(CMD_TICK, 8'h12, 16'h3456, 1'b1,
                '{1'b1, STOP_FINISH, 8'h00, START_RESUME, 1'b1, 8'hFF, 2'd1, 16'hFFFD, 1'b0});
        add_row(CMD_SUBMIT, 8'h01, 16'h0001, 1'b0, '0);
        add_row(CMD_TICK, 8'h00, 16'h0000, 1'b0, '0);
        add_row(CMD_TICK, 8'h00, 16'h0000, 1'b0, '0);
        // demotion saturates at the lowest level
        add_row(CMD_SUBMIT, 8'h02, 16'h0003, 1'b0, '0);
        add_row(CMD_TICK, 8'h00, 16'h0000, 1'b0, '0);
        // fill every slot, then one submit too many
        for (int i = 0; i < JOB_SLOTS - 2; i++)
            add_row(CMD_SUBMIT, ID_W'(8'h10 + i), TIME_W'(i % 3 + 1), 1'b0, '0);
        add_row(CMD_SUBMIT, 8'h80, 16'h00FF, 1'b1,
                '{1'b0, STOP_NONE, 8'h00, START_NONE, 1'b1, 8'h02, 2'd0, 16'h0003, 1'b0});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i])
            send_beat($urandom_range(0, 7), dir_rows[i]);

        // random bursts with varying submit mix
        beats_left     = RANDOM_BEATS;
        long_jobs_left = 3;
        while (beats_left > 0)
        begin
            burst_len = $urandom_range(8, 48);
            case ($urandom_range(0, 2))
                0:       submit_pct = 25;
                1:       submit_pct = 50;
                default: submit_pct = 75;
            endcase
            no_gap = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst_len && beats_left > 0; k++)
            begin
                row.cmd   = ($urandom_range(0, 99) < submit_pct) ? CMD_SUBMIT : CMD_TICK;
                row.id    = ID_W'($urandom_range(0, 255));
                row.typed = 1'b0;
                row.res   = '0;
                // long jobs are rare so slots keep turning over
                if (row.cmd == CMD_SUBMIT && long_jobs_left > 0 &&
                    $urandom_range(0, 199) == 0)
                begin
                    row.t = TIME_W'($urandom_range(0, 65535));
                    long_jobs_left--;
                end
                else if (row.cmd == CMD_SUBMIT)
                    row.t = TIME_W'($urandom_range(0, 6));
                else
                    row.t = TIME_W'($urandom_range(0, 65535));
                send_beat(no_gap ? 0 : $urandom_range(0, 7), row);
                beats_left--;
            end
        end

        // drain
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mlfs_pkg.sv
hdl/mlfs_ctrl.sv
hdl/mlfs_datapath.sv
hdl/multilevel_feedback_scheduler_core.sv
tb/multilevel_feedback_scheduler_core_test.sv
